FILE: hdl/vilc_pkg.sv
// Shared types and constants for the video interface line counter register block.
// No dependencies; files that use it refer to it by scoped names.
package vilc_pkg;

  // Request kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Register numbers (byte address bits 5:2)
  localparam logic [3:0] REG_CONTROL    = 4'd0;
  localparam logic [3:0] REG_ORIGIN     = 4'd1;
  localparam logic [3:0] REG_WIDTH      = 4'd2;
  localparam logic [3:0] REG_INTR_LINE  = 4'd3;
  localparam logic [3:0] REG_CUR_LINE   = 4'd4;
  localparam logic [3:0] REG_BURST      = 4'd5;
  localparam logic [3:0] REG_VSYNC      = 4'd6;
  localparam logic [3:0] REG_HSYNC      = 4'd7;
  localparam logic [3:0] REG_HSYNC_LEAP = 4'd8;
  localparam logic [3:0] REG_HVIDEO     = 4'd9;
  localparam logic [3:0] REG_VVIDEO     = 4'd10;
  localparam logic [3:0] REG_VBURST     = 4'd11;
  localparam logic [3:0] REG_XSCALE     = 4'd12;
  localparam logic [3:0] REG_YSCALE     = 4'd13;
  localparam logic [3:0] REG_TEST_ADDR  = 4'd14;
  localparam logic [3:0] REG_STAGED     = 4'd15;

  // Write masks, at the stored widths
  localparam logic [20:0] HSYNC_MASK = 21'h1F0FFF;
  localparam logic [27:0] LEAP_MASK  = 28'hFFF0FFF;
  localparam logic [25:0] VIDEO_MASK = 26'h3FF03FF;

  // Reset values
  localparam logic [31:0] CONTROL_RST   = 32'd3;
  localparam logic [11:0] WIDTH_RST     = 12'd320;
  localparam logic [9:0]  INTR_LINE_RST = 10'h3FF;
  localparam logic [29:0] BURST_RST     = 30'd1;
  localparam logic [9:0]  DEFAULT_VSYNC = 10'd525;
  localparam logic [20:0] HSYNC_RST     = 21'h1507FF;

  // Control bit that selects interlaced restart
  localparam int ILACE_BIT = 6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_raise;
    logic        irq_clear;
    logic        frame_end;
  } rsp_t;

endpackage

FILE: hdl/vilc_req_if.sv
// Request channel: valid/ready handshake with kind, register number and write data.
// Standalone; no package dependency.
interface vilc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  reg_index;
  logic [31:0] write_data;

  modport source (output valid, kind, reg_index, write_data, input ready);
  modport sink   (input valid, kind, reg_index, write_data, output ready);
endinterface

FILE: hdl/vilc_rsp_if.sv
// Response channel: valid/ready handshake with read data and event pulses.
// Standalone; no package dependency.
interface vilc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_raise;
  logic        irq_clear;
  logic        frame_end;

  modport source (output valid, read_data, irq_raise, irq_clear, frame_end, input ready);
  modport sink   (input valid, read_data, irq_raise, irq_clear, frame_end, output ready);
endinterface

FILE: hdl/vilc_in_stage.sv
// Input register stage: holds one request until the register file consumes it.
// Uses vilc_pkg::req_t.
module vilc_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vilc_pkg::req_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output vilc_pkg::req_t   out_item
);

  logic           hold_valid;
  vilc_pkg::req_t hold_item;

  // Refill whenever the held request leaves or the stage is empty
  assign in_ready  = !hold_valid || out_ready;
  assign out_valid = hold_valid;
  assign out_item  = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

endmodule

FILE: hdl/vilc_regfile.sv
// Register file, half-line counter and interrupt match logic.
// Uses vilc_pkg for codes, masks, reset values and the request/response types.
module vilc_regfile (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  vilc_pkg::req_t item,
  output vilc_pkg::rsp_t result
);

  logic [31:0] control_reg;
  logic [23:0] origin_reg;
  logic [11:0] width_reg;
  logic [9:0]  intr_line_reg;
  logic [10:0] line_counter;
  logic [29:0] burst_reg;
  logic [9:0]  vsync_reg;
  logic [20:0] hsync_reg;
  logic [27:0] hsync_leap_reg;
  logic [25:0] hvideo_reg;
  logic [25:0] vvideo_reg;
  logic [25:0] vburst_reg;
  logic [27:0] xscale_reg;
  logic [27:0] yscale_reg;
  logic [6:0]  test_addr_reg;
  logic [31:0] staged_data_reg;
  logic        match_level;

  logic        is_write;
  logic        is_tick;
  logic        is_intr_wr;
  logic [10:0] line_sum;
  logic        wrap;
  logic [10:0] line_counter_next;
  logic        match_level_next;
  logic [31:0] rd_mux;

  assign is_write   = (item.kind == vilc_pkg::KIND_WRITE);
  assign is_tick    = (item.kind == vilc_pkg::KIND_TICK);
  assign is_intr_wr = is_write && (item.reg_index == vilc_pkg::REG_INTR_LINE);

  // Advance two half-lines, wrap mod 2048; restart at vsync
  assign line_sum = line_counter + 11'd2;
  assign wrap     = (line_sum >= {1'b0, vsync_reg});
  assign line_counter_next = wrap ?
      {10'd0, ~line_sum[0] & control_reg[vilc_pkg::ILACE_BIT]} : line_sum;

  always_comb begin
    match_level_next = match_level;
    if (is_tick) begin
      match_level_next = (line_counter_next == {1'b0, intr_line_reg});
    end else if (is_intr_wr) begin
      match_level_next = (line_counter == {1'b0, item.write_data[9:0]});
    end
  end

  always_comb begin
    case (item.reg_index)
      vilc_pkg::REG_CONTROL:    rd_mux = control_reg;
      vilc_pkg::REG_ORIGIN:     rd_mux = {8'd0, origin_reg};
      vilc_pkg::REG_WIDTH:      rd_mux = {20'd0, width_reg};
      vilc_pkg::REG_INTR_LINE:  rd_mux = {22'd0, intr_line_reg};
      vilc_pkg::REG_CUR_LINE:   rd_mux = {21'd0, line_counter};
      vilc_pkg::REG_BURST:      rd_mux = {2'd0, burst_reg};
      vilc_pkg::REG_VSYNC:      rd_mux = {22'd0, vsync_reg};
      vilc_pkg::REG_HSYNC:      rd_mux = {11'd0, hsync_reg};
      vilc_pkg::REG_HSYNC_LEAP: rd_mux = {4'd0, hsync_leap_reg};
      vilc_pkg::REG_HVIDEO:     rd_mux = {6'd0, hvideo_reg};
      vilc_pkg::REG_VVIDEO:     rd_mux = {6'd0, vvideo_reg};
      vilc_pkg::REG_VBURST:     rd_mux = {6'd0, vburst_reg};
      vilc_pkg::REG_XSCALE:     rd_mux = {4'd0, xscale_reg};
      vilc_pkg::REG_YSCALE:     rd_mux = {4'd0, yscale_reg};
      vilc_pkg::REG_TEST_ADDR:  rd_mux = {25'd0, test_addr_reg};
      default:                  rd_mux = staged_data_reg;
    endcase
  end

  always_comb begin
    result.read_data = (item.kind == vilc_pkg::KIND_READ) ? rd_mux : 32'd0;
    result.irq_raise = (is_tick || is_intr_wr) && match_level_next && !match_level;
    result.irq_clear = is_write && (item.reg_index == vilc_pkg::REG_CUR_LINE);
    result.frame_end = is_tick && wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg     <= vilc_pkg::CONTROL_RST;
      origin_reg      <= '0;
      width_reg       <= vilc_pkg::WIDTH_RST;
      intr_line_reg   <= vilc_pkg::INTR_LINE_RST;
      line_counter    <= '0;
      burst_reg       <= vilc_pkg::BURST_RST;
      vsync_reg       <= vilc_pkg::DEFAULT_VSYNC;
      hsync_reg       <= vilc_pkg::HSYNC_RST;
      hsync_leap_reg  <= '0;
      hvideo_reg      <= '0;
      vvideo_reg      <= '0;
      vburst_reg      <= '0;
      xscale_reg      <= '0;
      yscale_reg      <= '0;
      test_addr_reg   <= '0;
      staged_data_reg <= '0;
      match_level     <= 1'b0;
    end else if (fire) begin
      match_level <= match_level_next;
      if (is_tick) begin
        line_counter <= line_counter_next;
      end
      if (is_write) begin
        case (item.reg_index)
          vilc_pkg::REG_CONTROL:    control_reg    <= item.write_data;
          vilc_pkg::REG_ORIGIN:     origin_reg     <= item.write_data[23:0];
          vilc_pkg::REG_WIDTH:      width_reg      <= item.write_data[11:0];
          vilc_pkg::REG_INTR_LINE:  intr_line_reg  <= item.write_data[9:0];
          vilc_pkg::REG_CUR_LINE:   ;  // clears the interrupt only
          vilc_pkg::REG_BURST:      burst_reg      <= item.write_data[29:0];
          vilc_pkg::REG_VSYNC: begin
            // zero loads the default
            vsync_reg <= (item.write_data[9:0] != 10'd0) ?
                         item.write_data[9:0] : vilc_pkg::DEFAULT_VSYNC;
          end
          vilc_pkg::REG_HSYNC:
            hsync_reg      <= item.write_data[20:0] & vilc_pkg::HSYNC_MASK;
          vilc_pkg::REG_HSYNC_LEAP:
            hsync_leap_reg <= item.write_data[27:0] & vilc_pkg::LEAP_MASK;
          vilc_pkg::REG_HVIDEO:
            hvideo_reg     <= item.write_data[25:0] & vilc_pkg::VIDEO_MASK;
          vilc_pkg::REG_VVIDEO:
            vvideo_reg     <= item.write_data[25:0] & vilc_pkg::VIDEO_MASK;
          vilc_pkg::REG_VBURST:
            vburst_reg     <= item.write_data[25:0] & vilc_pkg::VIDEO_MASK;
          vilc_pkg::REG_XSCALE:
            xscale_reg     <= item.write_data[27:0] & vilc_pkg::LEAP_MASK;
          vilc_pkg::REG_YSCALE:
            yscale_reg     <= item.write_data[27:0] & vilc_pkg::LEAP_MASK;
          vilc_pkg::REG_TEST_ADDR:  test_addr_reg  <= item.write_data[6:0];
          default:                  staged_data_reg <= item.write_data;
        endcase
      end
    end
  end

endmodule

FILE: hdl/vilc_out_stage.sv
// Result register: holds one response until the receiver takes it.
// Uses vilc_pkg::rsp_t.
module vilc_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vilc_pkg::rsp_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output vilc_pkg::rsp_t out_data
);

  logic           hold_valid;
  vilc_pkg::rsp_t hold_data;

  assign in_ready  = !hold_valid || out_ready;
  assign out_valid = hold_valid;
  assign out_data  = hold_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_data <= in_data;
    end
  end

endmodule

FILE: hdl/video_interface_line_counter_regs.sv
// Top level of the video interface line counter register block.
// Depends on vilc_pkg, vilc_req_if, vilc_rsp_if and the three vilc_* stages.
//
// Usage:
//   req (sink): one request per handshake. kind selects a register read,
//     a register write (reg_index, write_data) or a half-line tick.
//   rsp (source): exactly one response per request, in request order:
//     read_data for reads (zero otherwise) and the irq_raise, irq_clear and
//     frame_end pulses that the request caused.
// Path: an accepted request is held in the input register, then the update
//   logic writes its response into the result register, where the receiver
//   can take it.
// Throughput: one request per cycle, sustained while rsp.ready stays high; the
//   input register and the result register each refill in the cycle they are emptied.
// Reset (rst, synchronous): both stages empty, all registers at their
//   defaults, line counter zero, interrupt match level low.
// Stall: while rsp.ready is low, the result register holds its response;
//   one more request is taken into the input register, then req.ready drops.
module video_interface_line_counter_regs (
  input logic         clk,
  input logic         rst,
  vilc_req_if.sink    req,
  vilc_rsp_if.source  rsp
);

  vilc_pkg::req_t in_item;
  vilc_pkg::req_t cur_item;
  vilc_pkg::rsp_t cur_result;
  vilc_pkg::rsp_t out_data;
  logic           cur_valid;
  logic           res_ready;
  logic           fire;

  assign in_item.kind       = req.kind;
  assign in_item.reg_index  = req.reg_index;
  assign in_item.write_data = req.write_data;

  // Hold the incoming request
  vilc_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_item   (in_item),
    .out_valid (cur_valid),
    .out_ready (res_ready),
    .out_item  (cur_item)
  );

  // Apply the request to the state when the result register can take it
  assign fire = cur_valid && res_ready;

  vilc_regfile u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (cur_item),
    .result (cur_result)
  );

  vilc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cur_valid),
    .in_ready  (res_ready),
    .in_data   (cur_result),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (out_data)
  );

  assign rsp.read_data = out_data.read_data;
  assign rsp.irq_raise = out_data.irq_raise;
  assign rsp.irq_clear = out_data.irq_clear;
  assign rsp.frame_end = out_data.frame_end;

endmodule

FILE: hdl/vilc_checker.sv
// Port-level assertions for the video interface line counter register block.
// Bound to video_interface_line_counter_regs; no package dependency.
module vilc_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] read_data,
  input logic        irq_raise,
  input logic        irq_clear,
  input logic        frame_end
);

  // Drop any pending response on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // Hold a stalled response
  a_hold: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) &&
      $stable(irq_raise) && $stable(irq_clear) && $stable(frame_end))
    else $error("stalled response changed");

  // Read data comes only with reads, which raise no events
  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && (read_data != 32'd0) |-> !irq_raise && !irq_clear && !frame_end)
    else $error("event pulse with read data");

  // An interrupt clear comes from a write, which neither wraps nor raises
  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && irq_clear |-> !irq_raise && !frame_end)
    else $error("irq_clear together with another event");

endmodule

bind video_interface_line_counter_regs vilc_checker u_vilc_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .read_data (rsp.read_data),
  .irq_raise (rsp.irq_raise),
  .irq_clear (rsp.irq_clear),
  .frame_end (rsp.frame_end)
);

FILE: test/tb_video_interface_line_counter_regs.sv
`timescale 1ns / 100ps
// Testbench for video_interface_line_counter_regs: directed and random register traffic.
// Depends on vilc_pkg, vilc_req_if, vilc_rsp_if and the block itself.
module tb_video_interface_line_counter_regs;

  localparam int MAX_REPORTS = 10;
  // Request kind that the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vilc_req_if req ();
  vilc_rsp_if rsp ();

  video_interface_line_counter_regs dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #1 clk = ~clk;

  // Shadow copy of the register file, kept at the stored widths.
  logic [31:0] control_q;
  logic [23:0] origin_q;
  logic [11:0] width_q;
  logic [9:0]  intr_line_q;
  logic [10:0] line_q;
  logic [29:0] burst_q;
  logic [9:0]  vsync_q;
  logic [20:0] hsync_q;
  logic [27:0] leap_q;
  logic [25:0] hvideo_q;
  logic [25:0] vvideo_q;
  logic [25:0] vburst_q;
  logic [27:0] xscale_q;
  logic [27:0] yscale_q;
  logic [6:0]  test_addr_q;
  logic [31:0] staged_q;
  logic        match_q;

  // Responses predicted for accepted requests, oldest first.
  vilc_pkg::rsp_t pending_responses[$];

  // Idle rates for the current phase, in percent per cycle.
  int sender_idle_pct = 0;
  int stall_pct = 0;

  int mismatches = 0;
  int n_reads = 0;
  int n_writes = 0;
  int n_ticks = 0;
  int n_unused = 0;
  int n_frames = 0;
  int n_raises = 0;

  // Re-evaluate the interrupt match level; report its rising edge.
  function automatic logic refresh_match();
    logic prev;
    prev = match_q;
    match_q = (line_q == {1'b0, intr_line_q});
    return match_q && !prev;
  endfunction

  // Advance the shadow registers by one request and return the response it causes.
  function automatic vilc_pkg::rsp_t advance_registers(vilc_pkg::req_t r);
    vilc_pkg::rsp_t o;
    o = '0;
    case (r.kind)
      vilc_pkg::KIND_READ: begin
        n_reads++;
        case (r.reg_index)
          vilc_pkg::REG_CONTROL:    o.read_data = control_q;
          vilc_pkg::REG_ORIGIN:     o.read_data = {8'd0, origin_q};
          vilc_pkg::REG_WIDTH:      o.read_data = {20'd0, width_q};
          vilc_pkg::REG_INTR_LINE:  o.read_data = {22'd0, intr_line_q};
          vilc_pkg::REG_CUR_LINE:   o.read_data = {21'd0, line_q};
          vilc_pkg::REG_BURST:      o.read_data = {2'd0, burst_q};
          vilc_pkg::REG_VSYNC:      o.read_data = {22'd0, vsync_q};
          vilc_pkg::REG_HSYNC:      o.read_data = {11'd0, hsync_q};
          vilc_pkg::REG_HSYNC_LEAP: o.read_data = {4'd0, leap_q};
          vilc_pkg::REG_HVIDEO:     o.read_data = {6'd0, hvideo_q};
          vilc_pkg::REG_VVIDEO:     o.read_data = {6'd0, vvideo_q};
          vilc_pkg::REG_VBURST:     o.read_data = {6'd0, vburst_q};
          vilc_pkg::REG_XSCALE:     o.read_data = {4'd0, xscale_q};
          vilc_pkg::REG_YSCALE:     o.read_data = {4'd0, yscale_q};
          vilc_pkg::REG_TEST_ADDR:  o.read_data = {25'd0, test_addr_q};
          default:                  o.read_data = staged_q;
        endcase
      end
      vilc_pkg::KIND_WRITE: begin
        n_writes++;
        case (r.reg_index)
          vilc_pkg::REG_CONTROL:    control_q = r.write_data;
          vilc_pkg::REG_ORIGIN:     origin_q = r.write_data[23:0];
          vilc_pkg::REG_WIDTH:      width_q = r.write_data[11:0];
          vilc_pkg::REG_INTR_LINE: begin
            intr_line_q = r.write_data[9:0];
            o.irq_raise = refresh_match();
          end
          // Current line: counter and match level stay, only the clear pulses.
          vilc_pkg::REG_CUR_LINE:   o.irq_clear = 1'b1;
          vilc_pkg::REG_BURST:      burst_q = r.write_data[29:0];
          vilc_pkg::REG_VSYNC:
            vsync_q = (r.write_data[9:0] != 10'd0) ? r.write_data[9:0] :
                      vilc_pkg::DEFAULT_VSYNC;
          vilc_pkg::REG_HSYNC:      hsync_q = r.write_data[20:0] & vilc_pkg::HSYNC_MASK;
          vilc_pkg::REG_HSYNC_LEAP: leap_q = r.write_data[27:0] & vilc_pkg::LEAP_MASK;
          vilc_pkg::REG_HVIDEO:     hvideo_q = r.write_data[25:0] & vilc_pkg::VIDEO_MASK;
          vilc_pkg::REG_VVIDEO:     vvideo_q = r.write_data[25:0] & vilc_pkg::VIDEO_MASK;
          vilc_pkg::REG_VBURST:     vburst_q = r.write_data[25:0] & vilc_pkg::VIDEO_MASK;
          vilc_pkg::REG_XSCALE:     xscale_q = r.write_data[27:0] & vilc_pkg::LEAP_MASK;
          vilc_pkg::REG_YSCALE:     yscale_q = r.write_data[27:0] & vilc_pkg::LEAP_MASK;
          vilc_pkg::REG_TEST_ADDR:  test_addr_q = r.write_data[6:0];
          default:                  staged_q = r.write_data;
        endcase
      end
      vilc_pkg::KIND_TICK: begin
        n_ticks++;
        line_q = line_q + 11'd2;
        if (line_q >= {1'b0, vsync_q}) begin
          // Restart at the opposite field when interlaced, else at zero.
          line_q = {10'd0, ~line_q[0] & control_q[vilc_pkg::ILACE_BIT]};
          o.frame_end = 1'b1;
        end
        o.irq_raise = refresh_match();
      end
      default: n_unused++;
    endcase
    if (o.frame_end) n_frames++;
    if (o.irq_raise) n_raises++;
    return o;
  endfunction

  // Send one request: hold valid until the block takes it, then log its prediction.
  task automatic send_request(logic [1:0] kind, logic [3:0] idx, logic [31:0] data);
    vilc_pkg::req_t r;
    int gap;
    r.kind = kind;
    r.reg_index = idx;
    r.write_data = data;
    gap = 0;
    while (gap < 30 && int'($urandom_range(99)) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.kind <= r.kind;
    req.reg_index <= r.reg_index;
    req.write_data <= r.write_data;
    do @(posedge clk); while (!req.ready);
    pending_responses.push_back(advance_registers(r));
  endtask

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s mismatch: expected 0x%08h, got 0x%08h", $realtime, what, exp_v, act_v);
  endtask

  // Check every response the block hands over against the oldest prediction.
  always @(posedge clk) begin
    vilc_pkg::rsp_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_responses.size() == 0) begin
        note_mismatch("unrequested response", 32'd0, rsp.read_data);
      end else begin
        exp_r = pending_responses.pop_front();
        if (rsp.read_data !== exp_r.read_data)
          note_mismatch("read_data", exp_r.read_data, rsp.read_data);
        if (rsp.irq_raise !== exp_r.irq_raise)
          note_mismatch("irq_raise", {31'd0, exp_r.irq_raise}, {31'd0, rsp.irq_raise});
        if (rsp.irq_clear !== exp_r.irq_clear)
          note_mismatch("irq_clear", {31'd0, exp_r.irq_clear}, {31'd0, rsp.irq_clear});
        if (rsp.frame_end !== exp_r.frame_end)
          note_mismatch("frame_end", {31'd0, exp_r.frame_end}, {31'd0, rsp.frame_end});
      end
    end
  end

  // Receiver backpressure: drop ready at the phase's stall rate.
  always @(negedge clk) rsp.ready <= (int'($urandom_range(99)) >= stall_pct);

  // Registers that come out of reset with nonzero values.
  task automatic test_reset_values();
    send_request(vilc_pkg::KIND_READ, vilc_pkg::REG_CONTROL, 32'd0);
    send_request(vilc_pkg::KIND_READ, vilc_pkg::REG_WIDTH, 32'd0);
    send_request(vilc_pkg::KIND_READ, vilc_pkg::REG_INTR_LINE, 32'd0);
    send_request(vilc_pkg::KIND_READ, vilc_pkg::REG_BURST, 32'd0);
    send_request(vilc_pkg::KIND_READ, vilc_pkg::REG_VSYNC, 32'd0);
    send_request(vilc_pkg::KIND_READ, vilc_pkg::REG_HSYNC, 32'd0);
  endtask

  // Origin width truncation, vsync default loading, current-line clear, unused kind.
  task automatic test_register_writes();
    send_request(vilc_pkg::KIND_WRITE, vilc_pkg::REG_ORIGIN, 32'hFFFF_FFFF);
    send_request(vilc_pkg::KIND_READ, vilc_pkg::REG_ORIGIN, 32'd0);
    send_request(vilc_pkg::KIND_WRITE, vilc_pkg::REG_VSYNC, 32'd0);
    send_request(vilc_pkg::KIND_READ, vilc_pkg::REG_VSYNC, 32'd0);
    // Upper bits set but low ten clear: still loads the default.
    send_request(vilc_pkg::KIND_WRITE, vilc_pkg::REG_VSYNC, 32'hFFFF_FC00);
    send_request(vilc_pkg::KIND_WRITE, vilc_pkg::REG_CUR_LINE, 32'hFFFF_FFFF);
    send_request(KIND_UNUSED, vilc_pkg::REG_STAGED, 32'hFFFF_FFFF);
  endtask

  // Counter wrap at vsync, progressive and interlaced, and interrupt matches.
  task automatic test_line_counter();
    // matches counter at once
    send_request(vilc_pkg::KIND_WRITE, vilc_pkg::REG_INTR_LINE, 32'd0);
    send_request(vilc_pkg::KIND_WRITE, vilc_pkg::REG_VSYNC, 32'd5);
    repeat (3) send_request(vilc_pkg::KIND_TICK, 4'd0, 32'd0);  // 2, 4, wrap to 0
    send_request(vilc_pkg::KIND_WRITE, vilc_pkg::REG_CONTROL, 32'h43);
    repeat (3) send_request(vilc_pkg::KIND_TICK, 4'd0, 32'd0);  // 2, 4, wrap to field 1
    send_request(vilc_pkg::KIND_WRITE, vilc_pkg::REG_INTR_LINE, 32'd3);
    repeat (2) send_request(vilc_pkg::KIND_TICK, 4'd0, 32'd0);  // 3 matches, 5 wraps to 0
    send_request(vilc_pkg::KIND_READ, vilc_pkg::REG_CUR_LINE, 32'd0);
    send_request(vilc_pkg::KIND_WRITE, vilc_pkg::REG_CONTROL, 32'd0);
  endtask

  // Mostly ticks and writes that steer the counter, with reads and noise mixed in.
  task automatic test_random_traffic(int count, int idle_pct, int stall);
    int pick;
    logic [1:0] kind;
    logic [3:0] idx;
    logic [31:0] data;
    sender_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (count) begin
      pick = int'($urandom_range(99));
      idx = 4'($urandom_range(15));
      data = $urandom;
      if (pick < 45) begin
        kind = vilc_pkg::KIND_TICK;
      end else if (pick < 70) begin
        kind = vilc_pkg::KIND_WRITE;
        // Favor the registers that shape the counter's behavior.
        if ($urandom_range(99) < 40) begin
          case ($urandom_range(3))
            0: idx = vilc_pkg::REG_VSYNC;
            1: idx = vilc_pkg::REG_INTR_LINE;
            2: idx = vilc_pkg::REG_CONTROL;
            default: idx = vilc_pkg::REG_CUR_LINE;
          endcase
        end
        if (idx == vilc_pkg::REG_VSYNC) begin
          pick = int'($urandom_range(99));
          if (pick < 70) data = $urandom_range(40, 2);
          else if (pick < 80) data = {22'($urandom_range(4194303)), 10'd0};
        end else if (idx == vilc_pkg::REG_INTR_LINE && $urandom_range(99) < 70) begin
          data = $urandom_range(40);
        end
      end else if (pick < 95) begin
        kind = vilc_pkg::KIND_READ;
      end else begin
        kind = KIND_UNUSED;
      end
      send_request(kind, idx, data);
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.kind = vilc_pkg::KIND_READ;
    req.reg_index = vilc_pkg::REG_CONTROL;
    req.write_data = 32'd0;
    rsp.ready = 1'b0;

    control_q = vilc_pkg::CONTROL_RST;
    origin_q = '0;
    width_q = vilc_pkg::WIDTH_RST;
    intr_line_q = vilc_pkg::INTR_LINE_RST;
    line_q = '0;
    burst_q = vilc_pkg::BURST_RST;
    vsync_q = vilc_pkg::DEFAULT_VSYNC;
    hsync_q = vilc_pkg::HSYNC_RST;
    leap_q = '0;
    hvideo_q = '0;
    vvideo_q = '0;
    vburst_q = '0;
    xscale_q = '0;
    yscale_q = '0;
    test_addr_q = '0;
    staged_q = '0;
    match_q = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_register_writes();
    test_line_counter();
    test_random_traffic(300, 0, 0);
    test_random_traffic(300, 76, 0);
    test_random_traffic(300, 0, 76);
    test_random_traffic(300, 33, 33);

    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    // Keep waiting so that any stray response is caught.
    repeat (8) @(posedge clk);

    $display("Covered %0d reads, %0d writes, %0d ticks, %0d unused-kind requests;",
             n_reads, n_writes, n_ticks, n_unused);
    $display("saw %0d frame ends and %0d interrupt raises, %0d mismatches.",
             n_frames, n_raises, mismatches);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin
    #1_000_000;
    $display("Timeout waiting for responses");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
